### rtl/core/sprs_pkg.sv
// Shared types, constants and defaults for the sample playback resampler.
package sprs_pkg;

    localparam int SAMPLE_WORDS_DEF  = 65536;
    localparam int FRACTION_BITS_DEF = 48;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 16;
    localparam int WORD_W = 16;
    localparam int STEP_W = 52;
    localparam int VOL_W  = 16;
    localparam int LEN_W  = 17;
    localparam int PTR_W  = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(64'd281474976710656);
    localparam logic [VOL_W-1:0]  VOLUME_RESET = VOL_W'(32768);
    localparam logic [LEN_W-1:0]  LENGTH_RESET = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_PLAY  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_STEP   = 2'd1,
        CFG_VOLUME = 2'd2,
        CFG_LENGTH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic valid;
        logic active;
        logic stereo;
    } tick_meta_t;

endpackage

### rtl/core/sprs_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module sprs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

### rtl/core/sprs_ctrl.sv
// Command decode, play state, phase accumulator and read pointer.
module sprs_ctrl #(
    parameter int SAMPLE_WORDS  = sprs_pkg::SAMPLE_WORDS_DEF,
    parameter int FRACTION_BITS = sprs_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [sprs_pkg::CMD_W-1:0]         in_cmd,
    input  logic [sprs_pkg::ADDR_W-1:0]        in_addr,
    input  logic [sprs_pkg::WORD_W-1:0]        in_data,
    input  logic                               advance,
    input  logic                               stereo,
    input  logic [sprs_pkg::STEP_W-1:0]        step,
    input  logic [sprs_pkg::LEN_W-1:0]         length,
    output logic                               wr_en,
    output logic [$clog2(SAMPLE_WORDS)-1:0]    wr_addr,
    output logic [sprs_pkg::WORD_W-1:0]        wr_data,
    output logic [$clog2(SAMPLE_WORDS)-1:0]    rd_addr_a,
    output logic [$clog2(SAMPLE_WORDS)-1:0]    rd_addr_b,
    output sprs_pkg::tick_meta_t               meta
);

    import sprs_pkg::*;

    localparam int MEM_AW = $clog2(SAMPLE_WORDS);
    localparam int SUM_W  = STEP_W + 1;
    localparam int CARRY_W = SUM_W - FRACTION_BITS;
    localparam int ADV_W  = CARRY_W + 1;
    localparam int PSUM_W = ((ADV_W > PTR_W) ? ADV_W : PTR_W) + 1;
    localparam logic [PTR_W-1:0] PTR_MAX = '1;

    logic                     playing_reg;
    logic                     playing_next;
    logic [PTR_W-1:0]         ptr_reg;
    logic [PTR_W-1:0]         ptr_next;
    logic [FRACTION_BITS-1:0] phase_reg;
    logic [FRACTION_BITS-1:0] phase_next;
    tick_meta_t               meta_reg;
    tick_meta_t               meta_next;

    logic               tick_acc;
    logic               play_acc;
    logic               active_now;
    logic [SUM_W-1:0]   phase_sum;
    logic [CARRY_W-1:0] carry;
    logic [ADV_W-1:0]   adv;
    logic [PSUM_W-1:0]  ptr_sum;
    logic [PTR_W:0]     ptr_inc;

    assign tick_acc   = in_valid && advance && (in_cmd == CMD_TICK);
    assign play_acc   = in_valid && advance && (in_cmd == CMD_PLAY);
    assign wr_en      = in_valid && advance && (in_cmd == CMD_WRITE);
    assign wr_addr    = MEM_AW'(in_addr);
    assign wr_data    = in_data;
    assign active_now = playing_reg && (ptr_reg < PTR_W'(length));

    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(step);
    assign carry     = phase_sum[SUM_W-1:FRACTION_BITS];
    assign adv       = stereo ? {carry, 1'b0} : {1'b0, carry};
    assign ptr_sum   = PSUM_W'(ptr_reg) + PSUM_W'(adv);
    assign ptr_inc   = (PTR_W+1)'(ptr_reg) + (PTR_W+1)'(1);

    assign rd_addr_a = MEM_AW'(ptr_reg);
    assign rd_addr_b = MEM_AW'(ptr_inc);

    always_comb
    begin
        playing_next = playing_reg;
        ptr_next     = ptr_reg;
        phase_next   = phase_reg;
        priority if (play_acc)
        begin
            playing_next = 1'b1;
            ptr_next     = '0;
        end
        else if (tick_acc)
        begin
            if (active_now)
            begin
                phase_next = phase_sum[FRACTION_BITS-1:0];
                ptr_next   = (ptr_sum > PSUM_W'(PTR_MAX)) ? PTR_MAX
                                                          : ptr_sum[PTR_W-1:0];
            end
            else
            begin
                playing_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        meta_next        = meta_reg;
        if (advance)
        begin
            meta_next.valid  = tick_acc;
            meta_next.active = tick_acc && active_now;
            meta_next.stereo = stereo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= 1'b0;
            ptr_reg     <= '0;
            phase_reg   <= '0;
            meta_reg    <= '0;
        end
        else
        begin
            playing_reg <= playing_next;
            ptr_reg     <= ptr_next;
            phase_reg   <= phase_next;
            meta_reg    <= meta_next;
        end
    end

    assign meta = meta_reg;

`ifndef NO_ASSERTIONS
    a_play_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        play_acc |=> playing_reg && (ptr_reg == '0))
        else $error("play did not restart from word zero");

    a_active_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        meta_reg.active |-> meta_reg.valid)
        else $error("active flag set on an empty stage");

    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc && !active_now |=> !playing_reg && !meta_reg.active)
        else $error("silent tick left playback running");
`endif

endmodule

### rtl/core/sprs_scale.sv
// Volume multiply, floor shift, saturation and output register.
module sprs_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sprs_pkg::tick_meta_t          meta_in,
    input  logic [sprs_pkg::WORD_W-1:0]   word_a,
    input  logic [sprs_pkg::WORD_W-1:0]   word_b,
    input  logic [sprs_pkg::VOL_W-1:0]    volume,
    input  logic                          out_ready,
    output logic                          advance,
    output logic                          out_valid,
    output logic [sprs_pkg::WORD_W-1:0]   out_left,
    output logic [sprs_pkg::WORD_W-1:0]   out_right,
    output logic                          out_active
);

    import sprs_pkg::*;

    localparam int PROD_W  = WORD_W + VOL_W + 1;
    localparam int SHIFT   = 15;
    localparam int Q_W     = PROD_W - SHIFT;

    tick_meta_t                 s2_meta_reg;
    tick_meta_t                 s2_meta_next;
    logic signed [PROD_W-1:0]   p_left_reg;
    logic signed [PROD_W-1:0]   p_right_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_active_reg;
    logic                       out_active_next;
    logic [WORD_W-1:0]          out_left_reg;
    logic [WORD_W-1:0]          out_right_reg;

    logic signed [WORD_W-1:0]   w_left;
    logic signed [WORD_W-1:0]   w_right;
    logic signed [VOL_W:0]      vol_s;
    logic [WORD_W-1:0]          sat_left;
    logic [WORD_W-1:0]          sat_right;

    function automatic logic [WORD_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
        logic signed [Q_W-1:0] q;
        q = Q_W'(p >>> SHIFT);
        if ((q[Q_W-1:WORD_W-1] == '0) || (q[Q_W-1:WORD_W-1] == '1))
        begin
            saturate = q[WORD_W-1:0];
        end
        else
        begin
            saturate = q[Q_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
    endfunction

    assign advance = !out_valid_reg || out_ready;

    assign w_left  = signed'(word_a);
    assign w_right = meta_in.stereo ? signed'(word_b) : signed'(word_a);
    assign vol_s   = signed'({1'b0, volume});

    assign sat_left  = saturate(p_left_reg);
    assign sat_right = saturate(p_right_reg);

    always_comb
    begin
        s2_meta_next    = s2_meta_reg;
        out_valid_next  = out_valid_reg;
        out_active_next = out_active_reg;
        if (advance)
        begin
            s2_meta_next    = meta_in;
            out_valid_next  = s2_meta_reg.valid;
            out_active_next = s2_meta_reg.active;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_meta_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_active_reg <= 1'b0;
        end
        else
        begin
            s2_meta_reg    <= s2_meta_next;
            out_valid_reg  <= out_valid_next;
            out_active_reg <= out_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p_left_reg    <= PROD_W'(w_left) * PROD_W'(vol_s);
            p_right_reg   <= PROD_W'(w_right) * PROD_W'(vol_s);
            out_left_reg  <= s2_meta_reg.active ? sat_left : '0;
            out_right_reg <= s2_meta_reg.active ? sat_right : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;
    assign out_active = out_active_reg;

`ifndef NO_ASSERTIONS
    a_silence_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_active_reg |-> (out_left_reg == '0) && (out_right_reg == '0))
        else $error("silent frame carries non-zero data");

    a_s2_active_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s2_meta_reg.active |-> s2_meta_reg.valid)
        else $error("active flag set on an empty product stage");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_left_reg))
        else $error("frame lost while the receiver stalled");
`endif

endmodule

### rtl/core/sample_playback_resampler_top.sv
// Top level of the one-shot sample player with phase-accumulator resampling.
//
// Input stream: s_axis_tuser carries the command (write word, play, tick),
// s_axis_tdata the write address and the PCM word. Only a tick transaction
// produces an output frame; write and play take effect when accepted.
// Output stream: m_axis_tdata carries the left and right samples,
// m_axis_tuser the active flag (clear for silence after the end of play).
// Configuration: cfg_write with cfg_index and cfg_data sets one of channel
// mode, step increment, volume and sample length; write only while idle.
// Pipeline: an accepted tick passes the registered sample RAM read, the volume
// multiply register and saturation into the output register, in that order.
// Throughput: one transaction per cycle while the output is not stalled; the
// phase and pointer update in the acceptance cycle, so consecutive ticks need no gap.
// Reset: playback stops, pointer and phase clear, registers take their
// defaults; sample memory keeps no reset and must be written before use.
// Stall: while a frame waits, the whole pipeline holds and s_axis_tready
// drops; it rises again in the cycle the frame is taken.
module sample_playback_resampler_top #(
    parameter int SAMPLE_WORDS  = sprs_pkg::SAMPLE_WORDS_DEF,
    parameter int FRACTION_BITS = sprs_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // write_address, write_data
    input  logic [sprs_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // left_sample, right_sample
    output logic                                m_axis_tuser,  // active
    input  logic                                cfg_write,
    input  logic [sprs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sprs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import sprs_pkg::*;

    localparam int MEM_AW = $clog2(SAMPLE_WORDS);

    logic              mode_reg;
    logic [STEP_W-1:0] step_reg;
    logic [VOL_W-1:0]  volume_reg;
    logic [LEN_W-1:0]  length_reg;

    logic              advance;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [MEM_AW-1:0] rd_addr_a;
    logic [MEM_AW-1:0] rd_addr_b;
    logic [WORD_W-1:0] rd_data_a;
    logic [WORD_W-1:0] rd_data_b;
    tick_meta_t        meta;
    logic [WORD_W-1:0] out_left;
    logic [WORD_W-1:0] out_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            step_reg   <= STEP_RESET;
            volume_reg <= VOLUME_RESET;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:   mode_reg   <= cfg_data[0];
                CFG_STEP:   step_reg   <= cfg_data[STEP_W-1:0];
                CFG_VOLUME: volume_reg <= cfg_data[VOL_W-1:0];
                CFG_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    sprs_ctrl #(
        .SAMPLE_WORDS  (SAMPLE_WORDS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_addr   (s_axis_tdata[ADDR_W-1:0]),
        .in_data   (s_axis_tdata[ADDR_W+WORD_W-1:ADDR_W]),
        .advance   (advance),
        .stereo    (mode_reg),
        .step      (step_reg),
        .length    (length_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .meta      (meta)
    );

    sprs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SAMPLE_WORDS)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (advance),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    sprs_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .meta_in    (meta),
        .word_a     (rd_data_a),
        .word_b     (rd_data_b),
        .volume     (volume_reg),
        .out_ready  (m_axis_tready),
        .advance    (advance),
        .out_valid  (m_axis_tvalid),
        .out_left   (out_left),
        .out_right  (out_right),
        .out_active (m_axis_tuser)
    );

    assign s_axis_tready = advance;
    assign m_axis_tdata  = {out_right, out_left};

endmodule

### dv/sample_playback_resampler_checker.sv
// Frame predictor and scoreboard for the sample playback resampler.
`timescale 1ns / 100ps
module sample_playback_resampler_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // write_address, write_data
    input  logic [sprs_pkg::CMD_W-1:0]      s_axis_tuser,  // cmd
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [31:0]                     m_axis_tdata,  // left_sample, right_sample
    input  logic                            m_axis_tuser,  // active
    input  logic                            cfg_write,
    input  logic [sprs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sprs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              backlog,
    output int                              frames_seen,
    output int                              active_seen
);

    import sprs_pkg::*;

    localparam int FB    = FRACTION_BITS_DEF;
    localparam int SUM_W = STEP_W + 1;

    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic              active;
    } frame_t;

    logic [WORD_W-1:0] pcm_words [SAMPLE_WORDS_DEF];
    logic [PTR_W-1:0]  play_ptr;
    logic [FB-1:0]     phase_frac;
    logic              is_playing;

    logic              stereo_mode;
    logic [STEP_W-1:0] rate_step;
    logic [VOL_W-1:0]  gain;
    logic [LEN_W-1:0]  clip_length;

    frame_t due_frames[$];

    task automatic report_mismatch(input string text);
        $display("%0t ns  mismatch: %s", $time, text);
        mismatches++;
    endtask

    function automatic logic [WORD_W-1:0] apply_gain(input logic [WORD_W-1:0] word);
        logic signed [33:0] product;
        logic signed [33:0] scaled;
        product = $signed(word) * $signed({1'b0, gain});
        scaled  = product >>> 15;
        if (scaled > 34'sd32767)
            return 16'h7FFF;
        if (scaled < -34'sd32768)
            return 16'h8000;
        return scaled[WORD_W-1:0];
    endfunction

    function automatic frame_t predict_tick();
        frame_t            f;
        logic [SUM_W-1:0]  sum;
        logic [PTR_W:0]    advance;
        logic [PTR_W:0]    next_ptr;
        logic [ADDR_W-1:0] pair_addr;
        logic [WORD_W-1:0] lw;
        logic [WORD_W-1:0] rw;
        f = '0;
        if (!is_playing || play_ptr >= clip_length) begin
            is_playing = 1'b0;
            return f;
        end
        pair_addr = play_ptr[ADDR_W-1:0] + 1'b1;
        lw = pcm_words[play_ptr[ADDR_W-1:0]];
        rw = stereo_mode ? pcm_words[pair_addr] : lw;
        f.left   = apply_gain(lw);
        f.right  = apply_gain(rw);
        f.active = 1'b1;
        sum        = SUM_W'(phase_frac) + SUM_W'(rate_step);
        phase_frac = sum[FB-1:0];
        advance    = (PTR_W + 1)'(sum >> FB);
        if (stereo_mode)
            advance = advance << 1;
        next_ptr = {1'b0, play_ptr} + advance;
        play_ptr = next_ptr[PTR_W] ? {PTR_W{1'b1}} : next_ptr[PTR_W-1:0];
        return f;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        frame_t want;
        frame_t got;
        if (!rst_n) begin
            play_ptr    = '0;
            phase_frac  = '0;
            is_playing  = 1'b0;
            stereo_mode = 1'b0;
            rate_step   = STEP_RESET;
            gain        = VOLUME_RESET;
            clip_length = LENGTH_RESET;
            due_frames.delete();
            mismatches  = 0;
            frames_seen = 0;
            active_seen = 0;
            backlog    <= 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_MODE:   stereo_mode = cfg_data[0];
                    CFG_STEP:   rate_step   = cfg_data[STEP_W-1:0];
                    CFG_VOLUME: gain        = cfg_data[VOL_W-1:0];
                    CFG_LENGTH: clip_length = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.left   = m_axis_tdata[WORD_W-1:0];
                got.right  = m_axis_tdata[2*WORD_W-1:WORD_W];
                got.active = m_axis_tuser;
                frames_seen++;
                if (got.active === 1'b1)
                    active_seen++;
                if (due_frames.size() == 0)
                    report_mismatch($sformatf("frame %0d (%h %h %b) with no tick pending",
                                              frames_seen, got.left, got.right, got.active));
                else begin
                    want = due_frames.pop_front();
                    if (got.left !== want.left)
                        report_mismatch($sformatf("frame %0d left %h, want %h",
                                                  frames_seen, got.left, want.left));
                    if (got.right !== want.right)
                        report_mismatch($sformatf("frame %0d right %h, want %h",
                                                  frames_seen, got.right, want.right));
                    if (got.active !== want.active)
                        report_mismatch($sformatf("frame %0d active %b, want %b",
                                                  frames_seen, got.active, want.active));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    CMD_WRITE:
                        pcm_words[s_axis_tdata[ADDR_W-1:0]] = s_axis_tdata[ADDR_W +: WORD_W];
                    CMD_PLAY: begin
                        is_playing = 1'b1;
                        play_ptr   = '0;
                    end
                    CMD_TICK:
                        due_frames.push_back(predict_tick());
                    default: ;
                endcase
            end
            backlog <= due_frames.size();
        end
    end

endmodule

### dv/sample_playback_resampler_top_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the sample playback resampler.
`timescale 1ns / 100ps
module sample_playback_resampler_top_tb;
    import sprs_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
    localparam logic [STEP_W-1:0] STEP_UNITY  = STEP_W'(64'd281474976710656);
    localparam logic [STEP_W-1:0] STEP_MAX    = '1;
    localparam logic [LEN_W-1:0]  LENGTH_FULL = LEN_W'(SAMPLE_WORDS_DEF);
    localparam int WRITTEN_WORDS   = 128;
    localparam int RANDOM_ITEMS    = 460;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int IDLE_LIMIT      = 5000;
    localparam int TICK_CAP        = 30;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;  // write_address, write_data
    logic [CMD_W-1:0]      s_axis_tuser;  // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;  // left_sample, right_sample
    logic                  m_axis_tuser;  // active
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int backlog;
    int frames_seen;
    int active_seen;

    bit quiet;
    int stall_kicks;
    int sent;
    int useful_sent;
    int settings;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_playback_resampler_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sample_playback_resampler_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .backlog       (backlog),
        .frames_seen   (frames_seen),
        .active_seen   (active_seen)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] a,
                        input logic [WORD_W-1:0] d);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= {d, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
        if (c != CMD_UNUSED)
            useful_sent++;
    endtask

    // drop valid and wait until every frame is out and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic configure(input bit m, input logic [STEP_W-1:0] st,
                             input logic [VOL_W-1:0] vol, input logic [LEN_W-1:0] len);
        settle();
        write_reg(CFG_MODE, CFG_DATA_W'(m));
        write_reg(CFG_STEP, CFG_DATA_W'(st));
        write_reg(CFG_VOLUME, CFG_DATA_W'(vol));
        write_reg(CFG_LENGTH, CFG_DATA_W'(len));
        @(posedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic play_clip(input int ticks, input bit mixed);
        send(CMD_PLAY, 16'($urandom), 16'($urandom));
        for (int i = 0; i < ticks; i++) begin
            if (mixed && $urandom_range(0, 9) == 0)
                send(CMD_WRITE, 16'($urandom), 16'($urandom));
            send(CMD_TICK, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send(CMD_W'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic random_phase();
        bit                m;
        logic [STEP_W-1:0] st;
        logic [VOL_W-1:0]  vol;
        logic [LEN_W-1:0]  len;
        real               span;
        int                est;
        m = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0:       st = '0;
            1:       st = STEP_MAX;
            2:       st = STEP_UNITY;
            3:       st = STEP_W'({$urandom, $urandom});
            default: st = (STEP_W'($urandom_range(16384, 131072)) << 32) | STEP_W'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       vol = '0;
            1:       vol = '1;
            2:       vol = VOLUME_RESET;
            default: vol = VOL_W'($urandom);
        endcase
        case ($urandom_range(0, 11))
            0:       len = LEN_W'(WRITTEN_WORDS - 1);
            1:       len = LEN_W'($urandom_range(0, WRITTEN_WORDS - 1));
            default: len = LEN_W'($urandom_range(0, 24));
        endcase
        if (st == '0)
            est = TICK_CAP;
        else begin
            span = real'(len) * 281474976710656.0 / (real'(st) * (m ? 2.0 : 1.0));
            est  = (span > TICK_CAP) ? TICK_CAP : int'(span) + 2;
        end
        configure(m, st, vol, len);
        quiet = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(2, 4)) begin
            if ($urandom_range(0, 9) < 8)
                play_clip(($urandom_range(0, 3) == 0) ? $urandom_range(1, est) : est, 1'b1);
            else
                noise_burst();
        end
    endtask

    // receiver: random hold-offs, plus one long stall on request
    initial begin
        int stall_seen;
        int gap;
        stall_seen    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_kicks != stall_seen) begin
                stall_seen = stall_kicks;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else begin
                gap = quiet ? 0 : pick_gap();
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [WORD_W-1:0] extremes [6];
        int                base;
        extremes      = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'hC000};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_WRITE;
        cfg_write     = 1'b0;
        cfg_index     = CFG_MODE;
        cfg_data      = '0;
        quiet         = 1'b0;
        stall_kicks   = 0;
        sent          = 0;
        useful_sent   = 0;
        settings      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // idle tick, unused command, empty sample at reset defaults
        send(CMD_TICK, '0, '0);
        send(CMD_UNUSED, '1, '1);
        send(CMD_PLAY, '0, '0);
        send(CMD_TICK, '1, '1);

        // fill the low words; every later length but the full-memory one stays inside them
        quiet = 1'b1;
        for (int a = 0; a < WRITTEN_WORDS; a++)
            send(CMD_WRITE, ADDR_W'(a), (a < 6) ? extremes[a] : 16'($urandom));
        quiet = 1'b0;

        // mono at full gain: saturation both ways, end of playback, idle after end
        configure(1'b0, STEP_UNITY, '1, LEN_W'(6));
        play_clip(8, 1'b0);
        // stereo pairs with an odd length, muted
        configure(1'b1, STEP_UNITY, '0, LEN_W'(5));
        play_clip(4, 1'b0);
        // widest step over the full memory
        configure(1'b1, STEP_MAX, VOLUME_RESET, LENGTH_FULL);
        play_clip(3, 1'b0);
        // zero step holds the pointer
        configure(1'b0, '0, VOL_W'(12345), LEN_W'(3));
        play_clip(2, 1'b0);

        base = useful_sent;
        // hold the receiver off while ticks keep coming
        configure(1'b0, STEP_UNITY, VOL_W'(40000), LEN_W'(100));
        quiet = 1'b1;
        stall_kicks++;
        play_clip(80, 1'b0);
        quiet = 1'b0;
        while (useful_sent - base < RANDOM_ITEMS)
            random_phase();

        quiet = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d input transactions over %0d register settings",
                 sent, settings);
        $display("%0d frames checked: %0d from the sample, %0d silent, %0d mismatches",
                 frames_seen, active_seen, frames_seen - active_seen, mismatches);
        if (mismatches == 0 && backlog == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
